FILE: rtl/mce_pkg.sv
// Shared types and constants of the MIDI controller expander.
package mce_pkg;

  localparam int NSLOT   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] TYPE_CTRL = 8'hB0;
  localparam logic [7:0] TYPE_PROG = 8'hC0;
  localparam logic [7:0] TYPE_BEND = 8'hE0;
  localparam logic [7:0] BYTE_NONE = 8'hFF;

  localparam logic [2:0] CLS_7BIT  = 3'd0;
  localparam logic [2:0] CLS_14BIT = 3'd1;
  localparam logic [2:0] CLS_RPN   = 3'd2;
  localparam logic [2:0] CLS_NRPN  = 3'd3;
  localparam logic [2:0] CLS_INTRN = 3'd4;
  localparam logic [2:0] CLS_RPN14 = 3'd5;
  localparam logic [2:0] CLS_NRPN14 = 3'd6;

  localparam logic [15:0] CTL_PITCH = 16'h0000;
  localparam logic [15:0] CTL_PROG  = 16'h0001;

  localparam logic [19:0] CC_BANK_MSB = 20'h00;
  localparam logic [19:0] CC_BANK_LSB = 20'h20;
  localparam logic [19:0] CC_DATA_MSB = 20'h06;
  localparam logic [19:0] CC_DATA_LSB = 20'h26;
  localparam logic [19:0] CC_RPN_MSB  = 20'h65;
  localparam logic [19:0] CC_RPN_LSB  = 20'h64;
  localparam logic [19:0] CC_NRPN_MSB = 20'h63;
  localparam logic [19:0] CC_NRPN_LSB = 20'h62;

  localparam logic [3:0] DRUM_CHANNEL = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GM_DRUM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_SEND    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_PARAM   = 2'd3;

  typedef struct packed {
    logic        write_enable;
    logic        gm_drum_block;
    logic        null_send_enable;
    logic [15:0] null_param_value;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  event_type;
    logic [3:0]  channel;
    logic [18:0] data_a;
    logic [24:0] data_b;
  } item_t;

  typedef struct packed {
    logic [7:0]  typ;
    logic [19:0] a;
    logic [24:0] b;
  } msg_t;

  typedef struct packed {
    logic              item_v;
    logic              out_load;
    logic              item_done;
    logic [NSLOT-1:0]  pick;
  } emit_status_t;

endpackage

FILE: rtl/mce_cfg.sv
// Configuration registers of the MIDI controller expander.
module mce_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mce_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output mce_pkg::cfg_t                     cfg
);

  mce_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.write_enable     <= 1'b0;
      cfg_r.gm_drum_block    <= 1'b0;
      cfg_r.null_send_enable <= 1'b0;
      cfg_r.null_param_value <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mce_pkg::REG_WRITE_ENABLE: cfg_r.write_enable     <= cfg_wdata[0];
        mce_pkg::REG_GM_DRUM:      cfg_r.gm_drum_block    <= cfg_wdata[0];
        mce_pkg::REG_NULL_SEND:    cfg_r.null_send_enable <= cfg_wdata[0];
        mce_pkg::REG_NULL_PARAM:   cfg_r.null_param_value <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/mce_decode.sv
// Decodes one held event into a fixed set of message slots with valid bits.
module mce_decode (
  input  mce_pkg::item_t                          item,
  input  mce_pkg::cfg_t                           cfg,
  output mce_pkg::msg_t [mce_pkg::NSLOT-1:0]      slots,
  output logic [mce_pkg::NSLOT-1:0]               slot_valid
);

  logic [2:0]  cls;
  logic [7:0]  hb, lb, null_hi, null_lo;
  logic        nrpn;
  logic [19:0] a_hi7, a_lo7;
  logic [24:0] b_hi7, b_lo7;

  assign cls     = item.data_a[18:16];
  assign hb      = item.data_b[23:16];
  assign lb      = item.data_b[15:8];
  assign null_hi = cfg.null_param_value[15:8];
  assign null_lo = cfg.null_param_value[7:0];
  assign nrpn    = (cls == mce_pkg::CLS_NRPN) || (cls == mce_pkg::CLS_NRPN14);
  assign a_hi7   = {13'd0, item.data_a[14:8]};
  assign a_lo7   = {13'd0, item.data_a[6:0]};
  assign b_hi7   = {18'd0, item.data_b[13:7]};
  assign b_lo7   = {18'd0, item.data_b[6:0]};

  always_comb begin
    logic [mce_pkg::NSLOT-1:0] v;
    v = '0;
    for (int i = 0; i < mce_pkg::NSLOT; i++) begin
      slots[i] = '{typ: mce_pkg::TYPE_CTRL, a: '0, b: '0};
    end

    // Parameter select and null tail are shared by the RPN and NRPN classes.
    slots[4] = '{typ: mce_pkg::TYPE_CTRL,
                 a: nrpn ? mce_pkg::CC_NRPN_MSB : mce_pkg::CC_RPN_MSB,
                 b: {18'd0, null_hi[6:0]}};
    slots[5] = '{typ: mce_pkg::TYPE_CTRL,
                 a: nrpn ? mce_pkg::CC_NRPN_LSB : mce_pkg::CC_RPN_LSB,
                 b: {18'd0, null_lo[6:0]}};

    if (item.event_type != mce_pkg::TYPE_CTRL || cls == mce_pkg::CLS_7BIT) begin
      slots[0] = '{typ: item.event_type, a: {1'b0, item.data_a}, b: item.data_b};
      v[0] = 1'b1;
    end else begin
      unique case (cls)
        mce_pkg::CLS_14BIT: begin
          slots[0].a = a_hi7;
          slots[0].b = b_hi7;
          slots[1].a = a_lo7;
          slots[1].b = b_lo7;
          v[1:0] = 2'b11;
        end
        mce_pkg::CLS_RPN, mce_pkg::CLS_NRPN,
        mce_pkg::CLS_RPN14, mce_pkg::CLS_NRPN14: begin
          slots[0].a = nrpn ? mce_pkg::CC_NRPN_MSB : mce_pkg::CC_RPN_MSB;
          slots[0].b = {18'd0, item.data_a[14:8]};
          slots[1].a = nrpn ? mce_pkg::CC_NRPN_LSB : mce_pkg::CC_RPN_LSB;
          slots[1].b = {18'd0, item.data_a[6:0]};
          slots[2].a = mce_pkg::CC_DATA_MSB;
          v[2:0] = 3'b111;
          if (cls == mce_pkg::CLS_RPN || cls == mce_pkg::CLS_NRPN) begin
            slots[2].b = item.data_b;
          end else begin
            slots[2].b = b_hi7;
            slots[3].a = mce_pkg::CC_DATA_LSB;
            slots[3].b = b_lo7;
            v[3] = 1'b1;
          end
          v[4] = cfg.null_send_enable && (null_hi != mce_pkg::BYTE_NONE);
          v[5] = cfg.null_send_enable && (null_lo != mce_pkg::BYTE_NONE);
        end
        mce_pkg::CLS_INTRN: begin
          if (item.data_a[15:0] == mce_pkg::CTL_PITCH) begin
            slots[0] = '{typ: mce_pkg::TYPE_BEND, a: item.data_b[19:0], b: '0};
            v[0] = 1'b1;
          end else if (item.data_a[15:0] == mce_pkg::CTL_PROG &&
                       !(cfg.gm_drum_block && item.channel == mce_pkg::DRUM_CHANNEL)) begin
            slots[0] = '{typ: mce_pkg::TYPE_CTRL, a: mce_pkg::CC_BANK_MSB,
                         b: {17'd0, hb}};
            slots[1] = '{typ: mce_pkg::TYPE_CTRL, a: mce_pkg::CC_BANK_LSB,
                         b: {17'd0, lb}};
            slots[2] = '{typ: mce_pkg::TYPE_PROG, a: {13'd0, item.data_b[6:0]}, b: '0};
            v[0] = (hb != mce_pkg::BYTE_NONE);
            v[1] = (lb != mce_pkg::BYTE_NONE);
            v[2] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    slot_valid = cfg.write_enable ? v : '0;
  end

endmodule

FILE: rtl/mce_emit.sv
// Event holding register, slot walker and output register.
module mce_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  mce_pkg::cfg_t       cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  mce_pkg::item_t      in_item,
  output logic                out_tvalid,
  input  logic                out_tready,
  output mce_pkg::msg_t       out_msg,
  output logic [3:0]          out_channel,
  output logic                out_tlast,
  output mce_pkg::emit_status_t status
);

  mce_pkg::item_t                     item_r;
  logic                               item_v_r, item_v_nxt;
  logic [mce_pkg::NSLOT-1:0]          mask_r, mask_nxt;
  mce_pkg::msg_t [mce_pkg::NSLOT-1:0] slots;
  logic [mce_pkg::NSLOT-1:0]          slot_valid, rem, pick;
  mce_pkg::msg_t                      pick_msg;
  logic                               out_v_r, out_v_nxt;
  mce_pkg::msg_t                      out_msg_r;
  logic [3:0]                         out_ch_r;
  logic                               out_last_r;
  logic                               out_load, item_done, in_acc;

  mce_decode u_decode (
    .item       (item_r),
    .cfg        (cfg),
    .slots      (slots),
    .slot_valid (slot_valid)
  );

  assign rem = item_v_r ? (slot_valid & mask_r) : '0;

  // Lowest remaining slot goes out next; slot order is message order.
  always_comb begin
    logic found;
    found    = 1'b0;
    pick     = '0;
    pick_msg = slots[0];
    for (int i = 0; i < mce_pkg::NSLOT; i++) begin
      if (rem[i] && !found) begin
        found    = 1'b1;
        pick[i]  = 1'b1;
        pick_msg = slots[i];
      end
    end
  end

  assign out_load  = (rem != '0) && (!out_v_r || out_tready);
  assign item_done = item_v_r && ((rem == '0) || (out_load && (rem == pick)));
  assign in_tready = !item_v_r || item_done;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    item_v_nxt = item_v_r;
    mask_nxt   = mask_r;
    if (in_acc) begin
      item_v_nxt = 1'b1;
      mask_nxt   = '1;
    end else if (item_done) begin
      item_v_nxt = 1'b0;
    end else if (out_load) begin
      mask_nxt = mask_r & ~pick;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      mask_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      mask_r   <= mask_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (out_load) begin
      out_msg_r  <= pick_msg;
      out_ch_r   <= item_r.channel;
      out_last_r <= (rem & ~pick) == '0;
    end
  end

  assign out_tvalid  = out_v_r;
  assign out_msg     = out_msg_r;
  assign out_channel = out_ch_r;
  assign out_tlast   = out_last_r;

  assign status.item_v    = item_v_r;
  assign status.out_load  = out_load;
  assign status.item_done = item_done;
  assign status.pick      = pick;

endmodule

FILE: rtl/midi_controller_expander.sv
// Top level of the MIDI controller expander.
//
// Each input transaction is one MIDI event; controller events (type 0xB0) are
// expanded by controller class into a run of up to six plain MIDI messages,
// and other event types pass through as one message while writing is enabled.
// out_tlast marks the final message of each run; an event that expands to
// nothing produces no output. The event is held in an input register while
// its messages are picked one per cycle into an output register whenever the
// output is not stalled. An accepted event enters the input register and its
// first message then the output register. The next event is accepted in the
// same cycle that the last message of the current run moves to the output
// register, so single-message events stream at one per cycle if not stalled.
// When the receiver holds out_tready low, the output register keeps its
// message and the walk over the held event pauses; in_tready drops once the
// held event still has messages to send.
// The cfg port writes registers: 0 write enable, 1 GM drum block, 2 null tail
// enable, 3 null parameter value. Write it only while the block is idle.
// Synchronous reset clears the pipeline and loads the register defaults
// (all off, null parameter 0xFFFF).
module midi_controller_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // event_type[7:0], channel[11:8], data_a[30:12], data_b[55:31]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_type[7:0], out_channel[11:8], out_a[31:12], out_b[56:32], zero pad
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [mce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mce_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mce_pkg::cfg_t         cfg;
  mce_pkg::item_t        in_item;
  mce_pkg::msg_t         out_msg;
  logic [3:0]            out_channel;
  mce_pkg::emit_status_t status;

  assign in_item.event_type = in_tdata[7:0];
  assign in_item.channel    = in_tdata[11:8];
  assign in_item.data_a     = in_tdata[30:12];
  assign in_item.data_b     = in_tdata[55:31];

  mce_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mce_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_item     (in_item),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_msg     (out_msg),
    .out_channel (out_channel),
    .out_tlast   (out_tlast),
    .status      (status)
  );

  assign out_tdata = {7'd0, out_msg.b, out_msg.a, out_channel, out_msg.typ};

  // With writing disabled, no message is ever loaded.
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg.write_enable |-> !status.out_load)
    else $error("message loaded while writing is disabled");

  // Exactly one slot is picked whenever a message is loaded.
  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    status.out_load |-> $onehot(status.pick))
    else $error("slot pick is not one-hot");

  // The final message of a run carries tlast.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    status.out_load && status.item_done |=> out_tvalid && out_tlast)
    else $error("last message of a run without tlast");

  // With no event held, the input side is ready.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !status.item_v |-> in_tready)
    else $error("input stalled with no event held");

endmodule
